// ===== hw/rtl/mm4_pkg.sv =====
// mm4_pkg: shared constants, command codes, sequencer state and pipeline tag
// for the 4x4 fixed-point matrix multiplier. No dependencies.
package mm4_pkg;

	localparam int DIM       = 4;
	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int IDX_W     = $clog2(DIM);
	localparam int ADDR_W    = $clog2(DIM * DIM);
	localparam int PROD_W    = 2 * DATA_W;
	localparam int ACC_W     = PROD_W + IDX_W;
	localparam int CMD_W     = 2;
	localparam int POS_W     = 2;

	localparam logic [CMD_W-1:0] CMD_WRITE_LEFT  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE_RIGHT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMPUTE     = 2'd2;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIM - 1);

	// saturation bounds at accumulator width
	localparam logic signed [ACC_W-1:0] SAT_MAX =
		{{(ACC_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_MIN =
		{{(ACC_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} seq_state_t;

	// tag that travels with each multiply-accumulate step
	typedef struct packed {
		logic             vld;
		logic             first;
		logic             lastk;
		logic             fin;
		logic [IDX_W-1:0] r;
		logic [IDX_W-1:0] c;
	} tag_t;

	// arithmetic shift by the fraction width, then clamp to 32 bits
	function automatic logic signed [DATA_W-1:0] shift_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] sh;
		sh = acc >>> FRAC_BITS;
		if (sh > SAT_MAX) begin
			shift_sat = SAT_MAX[DATA_W-1:0];
		end else if (sh < SAT_MIN) begin
			shift_sat = SAT_MIN[DATA_W-1:0];
		end else begin
			shift_sat = sh[DATA_W-1:0];
		end
	endfunction

endpackage

// ===== hw/rtl/mm4_store.sv =====
// mm4_store: one matrix store, synchronous memory with a registered read.
// Per-entry valid bits make unwritten entries read as zero. Uses mm4_pkg.
module mm4_store (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           we,
	input  logic [mm4_pkg::ADDR_W-1:0]     waddr,
	input  logic [mm4_pkg::DATA_W-1:0]     wdata,
	input  logic [mm4_pkg::ADDR_W-1:0]     raddr,
	output logic [mm4_pkg::DATA_W-1:0]     rdata
);

	logic [mm4_pkg::DATA_W-1:0] mem [mm4_pkg::DIM * mm4_pkg::DIM];
	logic [mm4_pkg::DIM * mm4_pkg::DIM - 1:0] vld_q;
	logic [mm4_pkg::DATA_W-1:0] rd_q;
	logic                       rd_vld_q;

	// storage array, no reset
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	// written flags, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rd_vld_q <= vld_q[raddr];
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

// ===== hw/rtl/mm4_ctrl.sv =====
// mm4_ctrl: compute sequencer. Walks row, column and inner index, drives the
// store read addresses and issues the step tag. Uses mm4_pkg.
module mm4_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic                        fin_done,
	output logic                        busy,
	output logic [mm4_pkg::ADDR_W-1:0]  raddr_l,
	output logic [mm4_pkg::ADDR_W-1:0]  raddr_r,
	output mm4_pkg::tag_t               tag_s1
);

	mm4_pkg::seq_state_t state_q, state_d;
	logic [mm4_pkg::IDX_W-1:0] r_q, c_q, k_q;
	logic issue;
	logic issue_last;

	assign issue_last = (r_q == mm4_pkg::IDX_LAST) && (c_q == mm4_pkg::IDX_LAST) &&
		(k_q == mm4_pkg::IDX_LAST);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mm4_pkg::ST_IDLE: begin
				if (go) begin
					state_d = mm4_pkg::ST_RUN;
				end
			end
			mm4_pkg::ST_RUN: begin
				if (issue_last) begin
					state_d = mm4_pkg::ST_DRAIN;
				end
			end
			mm4_pkg::ST_DRAIN: begin
				if (fin_done) begin
					state_d = mm4_pkg::ST_IDLE;
				end
			end
			default: state_d = mm4_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		issue = 1'b0;
		busy  = 1'b1;
		case (state_q)
			mm4_pkg::ST_IDLE:  busy  = 1'b0;
			mm4_pkg::ST_RUN:   issue = 1'b1;
			mm4_pkg::ST_DRAIN: issue = 1'b0;
			default:           busy  = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mm4_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// index counters: k innermost, then column, then row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
			c_q <= '0;
			k_q <= '0;
		end else if (issue) begin
			if (k_q == mm4_pkg::IDX_LAST) begin
				k_q <= '0;
				if (c_q == mm4_pkg::IDX_LAST) begin
					c_q <= '0;
					r_q <= (r_q == mm4_pkg::IDX_LAST) ? '0 : r_q + 1'b1;
				end else begin
					c_q <= c_q + 1'b1;
				end
			end else begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// left[r][k] and right[k][c]
	assign raddr_l = mm4_pkg::ADDR_W'(int'(r_q) * mm4_pkg::DIM + int'(k_q));
	assign raddr_r = mm4_pkg::ADDR_W'(int'(k_q) * mm4_pkg::DIM + int'(c_q));

	// tag lines up with the registered read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.vld   <= issue;
			tag_s1.first <= (k_q == '0);
			tag_s1.lastk <= (k_q == mm4_pkg::IDX_LAST);
			tag_s1.fin   <= (r_q == mm4_pkg::IDX_LAST) && (c_q == mm4_pkg::IDX_LAST);
			tag_s1.r     <= r_q;
			tag_s1.c     <= c_q;
		end
	end

endmodule

// ===== hw/rtl/mm4_mac.sv =====
// mm4_mac: multiply, accumulate, shift-and-saturate and result register.
// Takes store read data aligned with the step tag. Uses mm4_pkg.
module mm4_mac (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [mm4_pkg::DATA_W-1:0]        a,
	input  logic [mm4_pkg::DATA_W-1:0]        b,
	input  mm4_pkg::tag_t                     tag_s1,
	output logic                              fin_done,
	output logic                              valid,
	output logic [mm4_pkg::POS_W-1:0]         out_row,
	output logic [mm4_pkg::POS_W-1:0]         out_col,
	output logic signed [mm4_pkg::DATA_W-1:0] product,
	output logic                              last
);

	logic signed [mm4_pkg::PROD_W-1:0] prod_s2;
	logic signed [mm4_pkg::ACC_W-1:0]  prod_ext;
	logic signed [mm4_pkg::ACC_W-1:0]  acc_s3;
	mm4_pkg::tag_t tag_s2, tag_s3;
	logic emit;

	// tag pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	// full-width signed product
	always_ff @(posedge clk) begin
		prod_s2 <= $signed(a) * $signed(b);
	end

	assign prod_ext = mm4_pkg::ACC_W'(prod_s2);

	// accumulator restarts on the first inner step
	always_ff @(posedge clk) begin
		if (tag_s2.vld) begin
			acc_s3 <= tag_s2.first ? prod_ext : acc_s3 + prod_ext;
		end
	end

	assign emit     = tag_s3.vld && tag_s3.lastk;
	assign fin_done = emit && tag_s3.fin;

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else begin
			valid <= emit;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_row <= mm4_pkg::POS_W'(tag_s3.r);
			out_col <= mm4_pkg::POS_W'(tag_s3.c);
			product <= mm4_pkg::shift_sat(acc_s3);
			last    <= tag_s3.fin;
		end
	end

endmodule

// ===== hw/rtl/matrix_multiply_4x4.sv =====
// matrix_multiply_4x4: top level, two element stores, sequencer and MAC.
// Depends on mm4_pkg, mm4_store, mm4_ctrl, mm4_mac.
//
// Element writes (left or right) leave busy low, so one can follow every
// cycle. A compute item holds busy high until the final result: one shared
// multiplier and one read port per store give one multiply-accumulate per
// cycle, 64 in all, passed through the store read, product and accumulator
// registers. The 16 results appear one at a time, the last (flagged by
// last) in the first cycle busy is low again. Each result shows on the
// ports for one cycle only, marked by valid; the receiver must take it then,
// as nothing holds it.
module matrix_multiply_4x4 (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [mm4_pkg::CMD_W-1:0]         command,
	input  logic [mm4_pkg::POS_W-1:0]         row,
	input  logic [mm4_pkg::POS_W-1:0]         col,
	input  logic signed [mm4_pkg::DATA_W-1:0] value,
	output logic                              valid,
	output logic [mm4_pkg::POS_W-1:0]         out_row,
	output logic [mm4_pkg::POS_W-1:0]         out_col,
	output logic signed [mm4_pkg::DATA_W-1:0] product,
	output logic                              last
);

	logic accept;
	logic addr_ok;
	logic we_l, we_r;
	logic go;
	logic fin_done;
	logic [mm4_pkg::ADDR_W-1:0] waddr;
	logic [mm4_pkg::ADDR_W-1:0] raddr_l, raddr_r;
	logic [mm4_pkg::DATA_W-1:0] rdata_l, rdata_r;
	mm4_pkg::tag_t tag_s1;

	// command decode
	assign accept  = start && !busy;
	assign addr_ok = (int'(row) < mm4_pkg::DIM) && (int'(col) < mm4_pkg::DIM);
	assign waddr   = mm4_pkg::ADDR_W'(int'(row) * mm4_pkg::DIM + int'(col));
	assign we_l    = accept && addr_ok && (command == mm4_pkg::CMD_WRITE_LEFT);
	assign we_r    = accept && addr_ok && (command == mm4_pkg::CMD_WRITE_RIGHT);
	assign go      = accept && (command == mm4_pkg::CMD_COMPUTE);

	mm4_store u_left (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (we_l),
		.waddr (waddr),
		.wdata (value),
		.raddr (raddr_l),
		.rdata (rdata_l)
	);

	mm4_store u_right (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (we_r),
		.waddr (waddr),
		.wdata (value),
		.raddr (raddr_r),
		.rdata (rdata_r)
	);

	mm4_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.fin_done(fin_done),
		.busy    (busy),
		.raddr_l (raddr_l),
		.raddr_r (raddr_r),
		.tag_s1  (tag_s1)
	);

	mm4_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.a       (rdata_l),
		.b       (rdata_r),
		.tag_s1  (tag_s1),
		.fin_done(fin_done),
		.valid   (valid),
		.out_row (out_row),
		.out_col (out_col),
		.product (product),
		.last    (last)
	);

	// a result strobe is never followed directly by another
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		valid |=> !valid)
		else $error("result strobes too close together");

	// a compute item raises busy
	a_go_busy: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> busy)
		else $error("busy not raised after compute item");

	// every result but the final one arrives while still busy
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !last) |-> busy)
		else $error("intermediate result while idle");

	// the final result ends the run
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && last) |-> (!busy && out_row == mm4_pkg::POS_W'(mm4_pkg::DIM - 1) &&
		out_col == mm4_pkg::POS_W'(mm4_pkg::DIM - 1)))
		else $error("final result misplaced");

	// no write lands in a store during a compute run
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !(we_l || we_r))
		else $error("store written while computing");

endmodule
